@@ sv/gsp_pkg.sv @@
package gsp_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned TOL_W    = 31;
  localparam int unsigned SWEEP_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALED_SOURCE = 2'd0,
    CFG_TOLERANCE     = 2'd1,
    CFG_MAX_SWEEPS    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RD_NORTH,
    RD_SOUTH,
    RD_WEST,
    RD_EAST,
    RD_CENTER,
    RD_EMIT
  } rd_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB_SRC
  } acc_op_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] cell_value;
    logic                      last_cell;
  } cell_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic                      result_last;
    logic                      converged;
    logic [SWEEP_W-1:0]        sweeps_done;
  } result_t;

  typedef struct packed {
    logic    load_wr;
    logic    load_clr;
    logic    rd_en;
    rd_sel_e rd_sel;
    acc_op_e acc_op;
    logic    nv_ld;
    logic    cell_wr;
    logic    chg_ld;
    logic    chg_max;
    logic    chg_clr;
    logic    pos_first;
    logic    pos_next;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    conv_ld;
    logic    conv_val;
    logic    emit_first;
    logic    emit_next;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic emit_last;
    logic within_tol;
    logic limit_hit;
  } status_t;

endpackage

@@ sv/gsp_stream_if.sv @@
interface gsp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/gauss_seidel_poisson_grid_top.sv @@
// Gauss-Seidel solver for the five-point Poisson stencil on a GRID_ROWS by GRID_COLS grid of
// signed Q16.16 values. Cells are loaded in row-major order at one transfer per cycle, and the
// transfer that carries last_cell starts solving; border cells keep their loaded values. Each
// interior cell update reads its four neighbors and its old value one after another through
// the single read port of the grid RAM, and every sweep ends with a convergence check. The
// grid is then returned in row-major order, one result at a time: the next cell is not read
// before the previous result is taken. Each result carries the converged flag and the sweep
// count. The grid RAM has no clearing pass after reset.
module gauss_seidel_poisson_grid_top #(
  parameter int unsigned GRID_ROWS = 3,
  parameter int unsigned GRID_COLS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gsp_stream_if.sink                    cell_i,
  gsp_stream_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [gsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gsp_pkg::VALUE_W-1:0]   cfg_data_i
);
  import gsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  gsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cell_i.valid),
    .in_last_i   (cell_i.payload.last_cell),
    .in_ready_o  (cell_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gsp_datapath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cell_value_i   (cell_i.payload.cell_value),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_value_o (result_o.payload.result_value),
    .result_last_o  (result_o.payload.result_last),
    .converged_o    (result_o.payload.converged),
    .sweeps_done_o  (result_o.payload.sweeps_done)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cell_i.ready && result_o.valid))
    else $error("input ready while a result is pending");

  a_reload_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.payload.result_last) |=> cell_i.ready)
    else $error("block did not return to loading after the final result");

  a_sweeps_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.payload.sweeps_done != 16'd0))
    else $error("result emitted with zero sweeps");
`endif

endmodule

@@ sv/gsp_ram.sv @@
module gsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/gsp_datapath.sv @@
module gsp_datapath #(
  parameter int unsigned GRID_ROWS = 3,
  parameter int unsigned GRID_COLS = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [gsp_pkg::VALUE_W-1:0]           cfg_data_i,
  input  logic signed [gsp_pkg::VALUE_W-1:0]    cell_value_i,
  input  gsp_pkg::cmd_t                         cmd_i,
  output gsp_pkg::status_t                      status_o,
  output logic signed [gsp_pkg::VALUE_W-1:0]    result_value_o,
  output logic                                  result_last_o,
  output logic                                  converged_o,
  output logic [gsp_pkg::SWEEP_W-1:0]           sweeps_done_o
);
  import gsp_pkg::*;

  localparam int unsigned CELLS = GRID_ROWS * GRID_COLS;
  localparam int unsigned IW    = $clog2(CELLS);
  localparam int unsigned LPW   = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(GRID_ROWS);
  localparam int unsigned CW    = $clog2(GRID_COLS);
  localparam int unsigned ACC_W = VALUE_W + 3;

  logic signed [VALUE_W-1:0] src_q;
  logic [TOL_W-1:0]          tol_q;
  logic [SWEEP_W-1:0]        max_sweeps_q;
  logic [LPW-1:0]            load_pos_q;
  logic [IW-1:0]             k_q;
  logic [RW-1:0]             row_q;
  logic [CW-1:0]             col_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [VALUE_W-1:0] old_q;
  logic signed [VALUE_W-1:0] nv_q;
  logic [VALUE_W-1:0]        chg_q;
  logic [VALUE_W-1:0]        max_chg_q;
  logic [SWEEP_W-1:0]        cnt_q;
  logic                      conv_q;
  logic [IW-1:0]             emit_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_last_q;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [IW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  logic signed [ACC_W-1:0]   rd_ext;
  logic signed [ACC_W-1:0]   src_ext;
  logic signed [ACC_W-1:0]   quarter;
  logic signed [VALUE_W-1:0] nv_d;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W:0]          abs_diff;
  logic                      load_room;
  logic [SWEEP_W-1:0]        cnt_inc;

  gsp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign load_room = load_pos_q < LPW'(CELLS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = nv_q;
    if (cmd_i.load_wr && load_room) begin
      ram_we    = 1'b1;
      ram_waddr = load_pos_q[IW-1:0];
      ram_wdata = cell_value_i;
    end else if (cmd_i.cell_wr) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_NORTH:  ram_raddr = k_q - IW'(GRID_COLS);
      RD_SOUTH:  ram_raddr = k_q + IW'(GRID_COLS);
      RD_WEST:   ram_raddr = k_q - IW'(1);
      RD_EAST:   ram_raddr = k_q + IW'(1);
      RD_CENTER: ram_raddr = k_q;
      RD_EMIT:   ram_raddr = emit_q;
      default:   ram_raddr = k_q;
    endcase
  end

  assign rd_ext  = {{(ACC_W - VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata};
  assign src_ext = {{(ACC_W - VALUE_W){src_q[VALUE_W-1]}}, src_q};
  assign quarter = acc_q >>> 2;

  always_comb begin
    if (quarter > $signed({{(ACC_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}})) begin
      nv_d = {1'b0, {(VALUE_W - 1){1'b1}}};
    end else if (quarter < $signed({{(ACC_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}})) begin
      nv_d = {1'b1, {(VALUE_W - 1){1'b0}}};
    end else begin
      nv_d = quarter[VALUE_W-1:0];
    end
  end

  assign diff     = {old_q[VALUE_W-1], old_q} - {nv_q[VALUE_W-1], nv_q};
  assign abs_diff = diff[VALUE_W] ? (VALUE_W + 1)'(-diff) : diff;
  assign cnt_inc  = cnt_q + SWEEP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q        <= VALUE_W'(65536);
      tol_q        <= '0;
      max_sweeps_q <= SWEEP_W'(1024);
      load_pos_q   <= '0;
      cnt_q        <= '0;
      conv_q       <= 1'b0;
      max_chg_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALED_SOURCE: src_q        <= cfg_data_i;
          CFG_TOLERANCE:     tol_q        <= cfg_data_i[TOL_W-1:0];
          CFG_MAX_SWEEPS:    max_sweeps_q <= cfg_data_i[SWEEP_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load_clr) begin
        load_pos_q <= '0;
      end else if (cmd_i.load_wr && load_room) begin
        load_pos_q <= load_pos_q + LPW'(1);
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_inc;
      end
      if (cmd_i.conv_ld) begin
        conv_q <= cmd_i.conv_val;
      end
      if (cmd_i.chg_clr) begin
        max_chg_q <= '0;
      end else if (cmd_i.chg_max && (chg_q > max_chg_q)) begin
        max_chg_q <= chg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.acc_op)
      ACC_LOAD:    acc_q <= rd_ext;
      ACC_ADD:     acc_q <= acc_q + rd_ext;
      ACC_SUB_SRC: acc_q <= acc_q - src_ext;
      default:     acc_q <= acc_q;
    endcase
    if (cmd_i.acc_op == ACC_SUB_SRC) begin
      old_q <= ram_rdata;
    end
    if (cmd_i.nv_ld) begin
      nv_q <= nv_d;
    end
    if (cmd_i.chg_ld) begin
      chg_q <= abs_diff[VALUE_W-1:0];
    end
    if (cmd_i.pos_first) begin
      k_q   <= IW'(GRID_COLS + 1);
      row_q <= RW'(1);
      col_q <= CW'(1);
    end else if (cmd_i.pos_next) begin
      if (col_q == CW'(GRID_COLS - 2)) begin
        col_q <= CW'(1);
        row_q <= row_q + RW'(1);
        k_q   <= k_q + IW'(3);
      end else begin
        col_q <= col_q + CW'(1);
        k_q   <= k_q + IW'(1);
      end
    end
    if (cmd_i.emit_first) begin
      emit_q <= '0;
    end else if (cmd_i.emit_next) begin
      emit_q <= emit_q + IW'(1);
    end
    if (cmd_i.out_ld) begin
      out_value_q <= ram_rdata;
      out_last_q  <= status_o.emit_last;
    end
  end

  assign status_o.pos_last   = (row_q == RW'(GRID_ROWS - 2)) && (col_q == CW'(GRID_COLS - 2));
  assign status_o.emit_last  = emit_q == IW'(CELLS - 1);
  assign status_o.within_tol = max_chg_q <= {1'b0, tol_q};
  assign status_o.limit_hit  = cnt_inc >= max_sweeps_q;

  assign result_value_o = out_value_q;
  assign result_last_o  = out_last_q;
  assign converged_o    = conv_q;
  assign sweeps_done_o  = cnt_q;

endmodule

@@ sv/gsp_ctrl.sv @@
module gsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  gsp_pkg::status_t   status_i,
  output gsp_pkg::cmd_t      cmd_o
);
  import gsp_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_N,
    ST_RD_S,
    ST_RD_W,
    ST_RD_E,
    ST_RD_C,
    ST_SUB,
    ST_NEW,
    ST_WR,
    ST_CMP,
    ST_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   in_xfer;
  logic   out_xfer;

  assign in_xfer  = in_valid_i && in_ready_q;
  assign out_xfer = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_xfer && in_last_i) begin
            state_q    <= ST_RD_N;
            in_ready_q <= 1'b0;
          end
        end
        ST_RD_N: state_q <= ST_RD_S;
        ST_RD_S: state_q <= ST_RD_W;
        ST_RD_W: state_q <= ST_RD_E;
        ST_RD_E: state_q <= ST_RD_C;
        ST_RD_C: state_q <= ST_SUB;
        ST_SUB:  state_q <= ST_NEW;
        ST_NEW:  state_q <= ST_WR;
        ST_WR:   state_q <= ST_CMP;
        ST_CMP:  state_q <= status_i.pos_last ? ST_CHK : ST_RD_N;
        ST_CHK: begin
          if (status_i.within_tol || status_i.limit_hit) begin
            state_q <= ST_EMIT_RD;
          end else begin
            state_q <= ST_RD_N;
          end
        end
        ST_EMIT_RD: state_q <= ST_EMIT_LD;
        ST_EMIT_LD: begin
          state_q     <= ST_EMIT_WAIT;
          out_valid_q <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (status_i.emit_last) begin
              state_q    <= ST_LOAD;
              in_ready_q <= 1'b1;
            end else begin
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_CENTER;
    cmd_o.acc_op = ACC_HOLD;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.load_wr = in_xfer;
        if (in_xfer && in_last_i) begin
          cmd_o.load_clr  = 1'b1;
          cmd_o.chg_clr   = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          cmd_o.pos_first = 1'b1;
        end
      end
      ST_RD_N: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_NORTH;
      end
      ST_RD_S: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_SOUTH;
        cmd_o.acc_op = ACC_LOAD;
      end
      ST_RD_W: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_WEST;
        cmd_o.acc_op = ACC_ADD;
      end
      ST_RD_E: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_EAST;
        cmd_o.acc_op = ACC_ADD;
      end
      ST_RD_C: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CENTER;
        cmd_o.acc_op = ACC_ADD;
      end
      ST_SUB: cmd_o.acc_op = ACC_SUB_SRC;
      ST_NEW: cmd_o.nv_ld = 1'b1;
      ST_WR: begin
        cmd_o.cell_wr = 1'b1;
        cmd_o.chg_ld  = 1'b1;
      end
      ST_CMP: begin
        cmd_o.chg_max  = 1'b1;
        cmd_o.pos_next = !status_i.pos_last;
      end
      ST_CHK: begin
        cmd_o.cnt_inc = 1'b1;
        if (status_i.within_tol || status_i.limit_hit) begin
          cmd_o.conv_ld    = 1'b1;
          cmd_o.conv_val   = status_i.within_tol;
          cmd_o.emit_first = 1'b1;
        end else begin
          cmd_o.chg_clr   = 1'b1;
          cmd_o.pos_first = 1'b1;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_EMIT;
      end
      ST_EMIT_LD: cmd_o.out_ld = 1'b1;
      ST_EMIT_WAIT: cmd_o.emit_next = out_xfer && !status_i.emit_last;
      default: begin
      end
    endcase
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ tb/gauss_seidel_poisson_grid_top_tb.sv @@
module gauss_seidel_poisson_grid_top_tb;
  import gsp_pkg::*;

  localparam int unsigned ROWS  = 3;
  localparam int unsigned COLS  = 5;
  localparam int unsigned CELLS = ROWS * COLS;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     LONG_HOLD   = 400;
  localparam int     SETTLE      = 12;
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;

  localparam logic [31:0] DIRECTED_CELLS [18] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF,
    32'h0000_0001, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678
  };

  typedef enum int {
    GRID_SMALL,
    GRID_FULL,
    GRID_EXTREME,
    GRID_MIXED,
    GRID_ALL_MAX,
    GRID_ALL_MIN
  } grid_kind_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VALUE_W-1:0]   cfg_data_i;

  gsp_stream_if #(.payload_t(cell_t))   cell_if ();
  gsp_stream_if #(.payload_t(result_t)) result_if ();

  gauss_seidel_poisson_grid_top #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cell_i    (cell_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  cell_t   pending_cells[$];
  result_t expected_results[$];
  int      errors = 0;
  int      cycle_count = 0;
  logic    hold_request;

  logic signed [31:0] grid_image [CELLS];
  int                 load_index;
  logic signed [31:0] source_term;
  logic [30:0]        tol_bound;
  logic [15:0]        sweep_limit;

  int burst_left;
  int gap_left;
  int free_left;
  int stall_left;
  int long_hold_left;
  logic long_hold_done;

  task automatic reset_solver_model();
    foreach (grid_image[i]) grid_image[i] = '0;
    load_index  = 0;
    source_term = 32'sd65536;
    tol_bound   = '0;
    sweep_limit = 16'd1024;
  endtask

  task automatic solve_grid();
    longint             sum;
    longint             q;
    longint             d;
    longint             chg;
    logic signed [31:0] nv;
    logic [15:0]        count;
    logic               conv;
    int                 k;
    int                 rr;
    int                 cc;
    result_t            r;
    count = '0;
    conv  = 1'b0;
    forever begin
      chg = 0;
      for (rr = 1; rr < ROWS - 1; rr++) begin
        for (cc = 1; cc < COLS - 1; cc++) begin
          k   = rr * COLS + cc;
          sum = longint'(grid_image[k-COLS]) + longint'(grid_image[k+COLS])
              + longint'(grid_image[k-1]) + longint'(grid_image[k+1])
              - longint'(source_term);
          q = sum >>> 2;
          if (q > VAL_MAX) nv = 32'sh7FFF_FFFF;
          else if (q < VAL_MIN) nv = 32'sh8000_0000;
          else nv = q[31:0];
          d = longint'(grid_image[k]) - longint'(nv);
          if (d < 0) d = -d;
          if (d > chg) chg = d;
          grid_image[k] = nv;
        end
      end
      count = count + 16'd1;
      if (chg <= longint'(tol_bound)) begin
        conv = 1'b1;
        break;
      end
      if (count >= sweep_limit) begin
        conv = 1'b0;
        break;
      end
    end
    for (k = 0; k < CELLS; k++) begin
      r.result_value = grid_image[k];
      r.result_last  = (k == CELLS - 1);
      r.converged    = conv;
      r.sweeps_done  = count;
      expected_results.push_back(r);
    end
    load_index = 0;
  endtask

  task automatic absorb_cell(input cell_t c);
    if (load_index < CELLS) begin
      grid_image[load_index] = c.cell_value;
      load_index++;
    end
    if (c.last_cell) solve_grid();
  endtask

  // Sender: bursts of transfers with random gaps in between.
  always @(posedge clk_i or negedge rst_ni) begin : drive_cells
    if (!rst_ni) begin
      cell_if.valid   <= 1'b0;
      cell_if.payload <= '0;
      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
    end else begin
      if (cell_if.valid && cell_if.ready) absorb_cell(cell_if.payload);
      if (cell_if.valid && !cell_if.ready) begin
        // Hold the offered cell until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        cell_if.valid <= 1'b0;
      end else if (pending_cells.size() > 0) begin
        cell_if.valid   <= 1'b1;
        cell_if.payload <= pending_cells.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        cell_if.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Receiver: checks every result transfer and stalls on its own pattern.
  always @(posedge clk_i or negedge rst_ni) begin : collect_results
    result_t got;
    result_t want;
    logic    nxt_ready;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      free_left      = 0;
      stall_left     = 0;
      long_hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got = result_if.payload;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h", $time,
                   got.result_value);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_value", want.result_value, got.result_value);
          check_field("result_last", 32'(want.result_last), 32'(got.result_last));
          check_field("converged", 32'(want.converged), 32'(got.converged));
          check_field("sweeps_done", 32'(want.sweeps_done), 32'(got.sweeps_done));
        end
        if (hold_request && !long_hold_done) begin
          long_hold_left = LONG_HOLD;
          long_hold_done = 1'b1;
        end
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        nxt_ready = 1'b0;
      end else begin
        if (free_left == 0 && stall_left == 0) begin
          free_left  = $urandom_range(1, 24);
          stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (free_left > 0) begin
          free_left--;
          nxt_ready = 1'b1;
        end else begin
          stall_left--;
          nxt_ready = 1'b0;
        end
      end
      result_if.ready <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value(input grid_kind_e kind);
    logic [31:0] v;
    grid_kind_e  k;
    k = kind;
    if (k == GRID_MIXED) k = grid_kind_e'($urandom_range(0, 2));
    v = $urandom();
    case (k)
      GRID_SMALL: v = {{12{v[19]}}, v[19:0]};
      GRID_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      GRID_ALL_MAX: v = 32'h7FFF_FFFF;
      GRID_ALL_MIN: v = 32'h8000_0000;
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_grid(input grid_kind_e kind);
    int    n;
    cell_t c;
    n = CELLS + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    for (int i = 0; i < n; i++) begin
      c.cell_value = pick_value(kind);
      c.last_cell  = (i == n - 1);
      pending_cells.push_back(c);
    end
  endtask

  task automatic write_registers(input logic signed [31:0] src, input logic [30:0] tol,
                                 input logic [15:0] limit);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SCALED_SOURCE;
    cfg_data_i <= src;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TOLERANCE;
    cfg_data_i <= {1'b0, tol};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_SWEEPS;
    cfg_data_i <= {16'd0, limit};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    source_term = src;
    tol_bound   = tol;
    sweep_limit = limit;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cells.size() != 0 || cell_if.valid || expected_results.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin
    logic signed [31:0] src;
    logic [30:0]        tol;
    logic [15:0]        limit;
    cell_t              c;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_SCALED_SOURCE;
    cfg_data_i   = '0;
    hold_request = 1'b0;
    reset_solver_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes under the reset settings, with surplus cells after a full grid.
    @(negedge clk_i);
    for (int i = 0; i < 18; i++) begin
      c.cell_value = DIRECTED_CELLS[i];
      c.last_cell  = (i == 17);
      pending_cells.push_back(c);
    end
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_registers(32'sh8000_0000, 31'd0, 16'd0);
          @(negedge clk_i);
          queue_grid(GRID_ALL_MAX);
        end
        1: begin
          write_registers(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
          @(negedge clk_i);
          queue_grid(GRID_ALL_MIN);
        end
        4: begin
          src = $urandom();
          write_registers({{12{src[19]}}, src[19:0]}, 31'd0, 16'd1024);
          @(negedge clk_i);
          queue_grid(GRID_FULL);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: src = '0;
            1: begin
              src = $urandom();
              src = {{12{src[19]}}, src[19:0]};
            end
            2: src = $urandom();
            default: src = 32'sd65536 * $urandom_range(0, 8);
          endcase
          case ($urandom_range(0, 2))
            0: tol = '0;
            1: tol = 31'($urandom_range(0, 4096));
            default: tol = 31'($urandom());
          endcase
          case ($urandom_range(0, 2))
            0: limit = 16'd1;
            1: limit = 16'($urandom_range(2, 48));
            default: limit = 16'($urandom_range(2, 16));
          endcase
          write_registers(src, tol, limit);
          @(negedge clk_i);
          if (p == 3) hold_request = 1'b1;
          queue_grid(grid_kind_e'($urandom_range(0, 3)));
          if (p == 3) queue_grid(grid_kind_e'($urandom_range(0, 3)));
        end
      endcase
      wait_drained();
    end

    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gsp_pkg.sv
sv/gsp_stream_if.sv
sv/gsp_ram.sv
sv/gsp_datapath.sv
sv/gsp_ctrl.sv
sv/gauss_seidel_poisson_grid_top.sv
tb/gauss_seidel_poisson_grid_top_tb.sv
